@@ rtl/core/bfaa_pkg.sv @@
`default_nettype none

package bfaa_pkg;

  localparam int CELLS_W     = 10;
  localparam int ID_W        = 6;
  localparam int KIND_W      = 2;
  localparam int COORD_W     = 32;
  localparam int LEN_W       = 32;
  localparam int PROD_W      = 2 * LEN_W;
  localparam int FRAC_BITS   = 16;
  localparam int AREA_W      = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = CELLS_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(1);
  localparam logic [AREA_W-1:0]  AREA_MAX    = {AREA_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_OTHER  = 2'd0,
    KIND_WALL   = 2'd1,
    KIND_INLET  = 2'd2,
    KIND_OUTLET = 2'd3
  } cell_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X = 2'd0,
    CFG_CELLS_Y = 2'd1,
    CFG_CELLS_Z = 2'd2
  } cfg_idx_e;

  // One classified cell on its way from the front to the back.
  typedef struct packed {
    logic             restart;
    logic             ok;
    logic             hit_x;
    logic             hit_y;
    logic             hit_z;
    logic [LEN_W-1:0] len_x;
    logic [LEN_W-1:0] len_y;
    logic [LEN_W-1:0] len_z;
  } face_job_t;

  // Absolute coordinate difference; zero on the low ghost layer.
  function automatic logic [LEN_W-1:0] edge_len(input logic [COORD_W-1:0] here,
                                                input logic [COORD_W-1:0] prev,
                                                input logic               at_zero);
    logic [COORD_W:0] diff;
    logic [COORD_W:0] mag;
    diff = {here[COORD_W-1], here} - {prev[COORD_W-1], prev};
    mag  = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;
    return at_zero ? '0 : mag[LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bfaa_cell_if.sv @@
`default_nettype none

interface bfaa_cell_if #(
  parameter int INDEX_BITS = 10
);
  logic                        valid;
  logic                        ready;
  logic                        restart;
  logic [1:0]                  cell_kind;
  logic [INDEX_BITS-1:0]       index_i;
  logic [INDEX_BITS-1:0]       index_j;
  logic [INDEX_BITS-1:0]       index_k;
  logic [5:0]                  boundary_id;
  logic signed [31:0]          x_here;
  logic signed [31:0]          x_before;
  logic signed [31:0]          y_here;
  logic signed [31:0]          y_before;
  logic signed [31:0]          z_here;
  logic signed [31:0]          z_before;

  modport source (
    output valid, restart, cell_kind, index_i, index_j, index_k, boundary_id,
           x_here, x_before, y_here, y_before, z_here, z_before,
    input  ready
  );

  modport sink (
    input  valid, restart, cell_kind, index_i, index_j, index_k, boundary_id,
           x_here, x_before, y_here, y_before, z_here, z_before,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bfaa_result_if.sv @@
`default_nettype none

interface bfaa_result_if;
  logic        valid;
  logic        ready;
  logic        counted;
  logic [47:0] added_area;
  logic [47:0] bin_total;

  modport source (
    output valid, counted, added_area, bin_total,
    input  ready
  );

  modport sink (
    input  valid, counted, added_area, bin_total,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bfaa_ram.sv @@
`default_nettype none

module bfaa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bfaa_fifo.sv @@
`default_nettype none

module bfaa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bfaa_front.sv @@
`default_nettype none

module bfaa_front import bfaa_pkg::*; #(
  parameter int NUM_BOUNDARIES = 64,
  parameter int INDEX_BITS     = 10,
  localparam int NUM_BINS      = 3 * NUM_BOUNDARIES,
  localparam int ADDR_W        = $clog2(NUM_BINS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bfaa_cell_if.sink                  cell_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output face_job_t                  job_o,
  output logic [ADDR_W-1:0]          addr_o
);

  // Wide enough for both the cell index and the far face index.
  localparam int CMP_W = (INDEX_BITS > CELLS_W + 1) ? INDEX_BITS : CELLS_W + 1;

  logic [CELLS_W-1:0] cells_x_q, cells_y_q, cells_z_q;
  cell_kind_e         kind;
  logic               id_ok;
  logic [ADDR_W-1:0]  base;
  logic               zero_i, zero_j, zero_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CELLS_RESET;
      cells_y_q <= CELLS_RESET;
      cells_z_q <= CELLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CELLS_X: cells_x_q <= cfg_data_i;
        CFG_CELLS_Y: cells_y_q <= cfg_data_i;
        CFG_CELLS_Z: cells_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign kind   = cell_kind_e'(cell_i.cell_kind);
  assign id_ok  = int'(cell_i.boundary_id) < NUM_BOUNDARIES;
  assign zero_i = (cell_i.index_i == '0);
  assign zero_j = (cell_i.index_j == '0);
  assign zero_k = (cell_i.index_k == '0);

  always_comb begin
    case (kind)
      KIND_WALL:   base = '0;
      KIND_INLET:  base = ADDR_W'(NUM_BOUNDARIES);
      KIND_OUTLET: base = ADDR_W'(2 * NUM_BOUNDARIES);
      default:     base = '0;
    endcase
  end

  always_comb begin
    job_o.restart = cell_i.restart;
    job_o.ok      = (kind != KIND_OTHER) && id_ok;
    job_o.hit_x   = zero_i ||
                    (CMP_W'(cell_i.index_i) == CMP_W'(cells_x_q) + CMP_W'(1));
    job_o.hit_y   = zero_j ||
                    (CMP_W'(cell_i.index_j) == CMP_W'(cells_y_q) + CMP_W'(1));
    job_o.hit_z   = zero_k ||
                    (CMP_W'(cell_i.index_k) == CMP_W'(cells_z_q) + CMP_W'(1));
    job_o.len_x   = edge_len(cell_i.x_here, cell_i.x_before, zero_i);
    job_o.len_y   = edge_len(cell_i.y_here, cell_i.y_before, zero_j);
    job_o.len_z   = edge_len(cell_i.z_here, cell_i.z_before, zero_k);
    addr_o        = job_o.ok ? base + ADDR_W'(cell_i.boundary_id) : '0;
  end

  assign cell_i.ready = !full_i;
  assign push_o       = cell_i.valid && !full_i;

endmodule

`default_nettype wire

@@ rtl/core/bfaa_back.sv @@
`default_nettype none

module bfaa_back import bfaa_pkg::*; #(
  parameter int NUM_BOUNDARIES = 64,
  localparam int NUM_BINS      = 3 * NUM_BOUNDARIES,
  localparam int ADDR_W        = $clog2(NUM_BINS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire face_job_t         job_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  output logic                   pop_o,
  bfaa_result_if.source          result_o
);

  localparam int SUM_W = AREA_W + 2;

  // The whole back pipeline moves together whenever the output register can take an item.
  logic adv;

  // Product stage.
  logic              mul_vld_q;
  logic              mul_restart_q, mul_ok_q;
  logic [2:0]        mul_hit_q;
  logic [ADDR_W-1:0] mul_addr_q;
  logic [PROD_W-1:0] prod_yz_q, prod_zx_q, prod_xy_q;

  // Sum stage; the bin read for this item arrives alongside it.
  logic              sum_vld_q;
  logic              sum_restart_q, sum_ok_q, sum_hit_q;
  logic [ADDR_W-1:0] sum_addr_q;
  logic [AREA_W-1:0] sum_added_q;
  logic [AREA_W-1:0] ram_rdata;
  logic              fwd_q;
  logic [AREA_W-1:0] fwd_data_q;

  logic [NUM_BINS-1:0] bin_valid_q, bin_valid_d;

  logic [AREA_W-1:0] area_x, area_y, area_z;
  logic [SUM_W-1:0]  face_sum;
  logic [AREA_W-1:0] added;
  logic              cur_valid;
  logic [AREA_W-1:0] cur_total;
  logic [AREA_W:0]   acc;
  logic [AREA_W-1:0] new_total;
  logic              wr_en;

  logic              out_vld_q;
  logic              out_counted_q;
  logic [AREA_W-1:0] out_added_q, out_total_q;

  assign adv   = !out_vld_q || result_o.ready;
  assign pop_o = adv && job_valid_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_restart_q <= job_i.restart;
      mul_ok_q      <= job_i.ok;
      mul_hit_q     <= {job_i.hit_z, job_i.hit_y, job_i.hit_x};
      mul_addr_q    <= addr_i;
      prod_yz_q     <= PROD_W'(job_i.len_y) * PROD_W'(job_i.len_z);
      prod_zx_q     <= PROD_W'(job_i.len_z) * PROD_W'(job_i.len_x);
      prod_xy_q     <= PROD_W'(job_i.len_x) * PROD_W'(job_i.len_y);
    end
  end

  // Sum of the matched face areas, each truncated to Q32.16, saturated.
  always_comb begin
    area_x   = mul_hit_q[0] ? prod_yz_q[PROD_W-1:FRAC_BITS] : '0;
    area_y   = mul_hit_q[1] ? prod_zx_q[PROD_W-1:FRAC_BITS] : '0;
    area_z   = mul_hit_q[2] ? prod_xy_q[PROD_W-1:FRAC_BITS] : '0;
    face_sum = SUM_W'(area_x) + SUM_W'(area_y) + SUM_W'(area_z);
    added    = (face_sum > SUM_W'(AREA_MAX)) ? AREA_MAX : face_sum[AREA_W-1:0];
  end

  bfaa_ram #(
    .WIDTH (AREA_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (sum_addr_q),
    .wdata_i (new_total),
    .re_i    (adv),
    .raddr_i (mul_addr_q),
    .rdata_o (ram_rdata)
  );

  // Accumulate into the bin. A restart in this item hides every older total.
  always_comb begin
    cur_valid = !sum_restart_q && bin_valid_q[sum_addr_q];
    cur_total = cur_valid ? (fwd_q ? fwd_data_q : ram_rdata) : '0;
    acc       = (AREA_W + 1)'(cur_total) + (AREA_W + 1)'(sum_added_q);
    new_total = acc[AREA_W] ? AREA_MAX : acc[AREA_W-1:0];
    wr_en     = adv && sum_vld_q && sum_ok_q && sum_hit_q;
  end

  // A restart drops every bin; the bin written by the same item is live again.
  always_comb begin
    bin_valid_d = bin_valid_q;
    if (sum_vld_q && sum_restart_q) begin
      bin_valid_d = '0;
    end
    if (wr_en) begin
      bin_valid_d[sum_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_restart_q <= mul_restart_q;
      sum_ok_q      <= mul_ok_q;
      sum_hit_q     <= |mul_hit_q;
      sum_addr_q    <= mul_addr_q;
      sum_added_q   <= added;
      fwd_data_q    <= new_total;
      out_counted_q <= sum_ok_q && sum_hit_q;
      out_added_q   <= (sum_ok_q && sum_hit_q) ? sum_added_q : '0;
      out_total_q   <= !sum_ok_q ? '0 : (sum_hit_q ? new_total : cur_total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q   <= 1'b0;
      sum_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      fwd_q       <= 1'b0;
      bin_valid_q <= '0;
    end else if (adv) begin
      mul_vld_q   <= job_valid_i;
      sum_vld_q   <= mul_vld_q;
      out_vld_q   <= sum_vld_q;
      // The RAM hands the item behind a stale total when it reads the bin being written.
      fwd_q       <= wr_en && (sum_addr_q == mul_addr_q);
      bin_valid_q <= bin_valid_d;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.counted    = out_counted_q;
  assign result_o.added_area = out_added_q;
  assign result_o.bin_total  = out_total_q;

endmodule

`default_nettype wire

@@ rtl/core/boundary_face_area_accumulator_top.sv @@
// Boundary face area accumulator. Each item is one boundary cell; the block
// forms its edge lengths along x, y and z, adds the areas of the grid faces the cell lies
// on into a saturating Q32.16 bin selected by cell kind and boundary id, and
// returns exactly one result item per input item, in order. One item can be
// accepted every clock cycle while the queue is not full. An item waits in the
// queue behind the classifier, then passes the product stage (three 32x32
// multipliers) and the face sum stage while the bin is read; the bin's
// read-modify-write then lands in the output register, which presents the
// result. The single bin RAM is read as an item enters the face sum stage and
// written as it leaves it; a total just written is forwarded to the following
// item, so back-to-back cells on the same bin still run at full rate. A set
// restart flag clears every bin at once through per-bin valid flags; there is
// no clearing pass after reset. The cells_x, cells_y and cells_z registers are
// written through the configuration port at indexes 0, 1 and 2 (writes to
// others are ignored); the user must write them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module boundary_face_area_accumulator_top import bfaa_pkg::*; #(
  parameter int NUM_BOUNDARIES = 64,
  parameter int INDEX_BITS     = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bfaa_cell_if.sink                  cell_i,
  bfaa_result_if.source              result_o
);

  localparam int NUM_BINS = 3 * NUM_BOUNDARIES;
  localparam int ADDR_W   = $clog2(NUM_BINS);
  localparam int QUEUE_W  = $bits(face_job_t) + ADDR_W;

  // Front side: classification of the accepted cell.
  logic              push;
  face_job_t         push_job;
  logic [ADDR_W-1:0] push_addr;
  logic              queue_full;

  // Back side: the item at the head of the queue.
  logic              pop;
  logic              head_valid;
  face_job_t         head_job;
  logic [ADDR_W-1:0] head_addr;

  bfaa_front #(
    .NUM_BOUNDARIES (NUM_BOUNDARIES),
    .INDEX_BITS     (INDEX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_i     (cell_i),
    .full_i     (queue_full),
    .push_o     (push),
    .job_o      (push_job),
    .addr_o     (push_addr)
  );

  // The queue lets the front keep accepting while the result side is stalled, until the queue is full.
  bfaa_fifo #(
    .WIDTH (QUEUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_job, push_addr}),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  ({head_job, head_addr})
  );

  bfaa_back #(
    .NUM_BOUNDARIES (NUM_BOUNDARIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .addr_i      (head_addr),
    .pop_o       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
